@@ hw/rtl/tdf_pkg.sv @@
`default_nettype none

package tdf_pkg;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned MULT_BITS  = 5;
  localparam int unsigned DIV_BITS   = (VALUE_BITS + 2) / 2;
  localparam int unsigned STEP_BITS  = $clog2(VALUE_BITS);

  localparam int unsigned FIRST_ODD_DIVISOR = 3;
  localparam int unsigned EVEN_PRIME        = 2;
  localparam int unsigned DIVISOR_STEP      = 2;

  typedef enum logic [1:0] {
    STATUS_FACTOR = 2'd0,
    STATUS_ONE    = 2'd1,
    STATUS_ZERO   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIV_BITS-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quot;
    logic [DIV_BITS-1:0]   rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/trial_division_factorizer_core.sv @@
`default_nettype none

// Sequence: zero and one go from idle to the emit state, which loads their single beat into the
// output register. Otherwise the strip state removes one factor of two per step; a 31-bit prime then
// needs about 23200 trial divisions in the shared bit-serial divider, which sets the rate.
// Throughput: one value at a time; input stalls until the last beat sits in the output register.
// Reset: rst_ni is asynchronous and active low; it returns the sequencer to idle and drops
// the output valid.
module trial_division_factorizer_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tdf_pkg::VALUE_BITS-1:0]    value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tdf_pkg::VALUE_BITS-1:0]         prime_o,
  output logic [tdf_pkg::MULT_BITS-1:0]          multiplicity_o,
  output logic                                   last_o,
  output tdf_pkg::status_e                       status_o
);
  import tdf_pkg::*;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [DIV_BITS-1:0]   d_q, d_d;
  logic [MULT_BITS-1:0]  e_q, e_d;
  logic                  inner_q, inner_d;
  logic [VALUE_BITS-1:0] pend_prime_q, pend_prime_d;
  logic [MULT_BITS-1:0]  pend_mult_q, pend_mult_d;
  logic                  pend_last_q, pend_last_d;
  status_e               pend_status_q, pend_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_prime_q;
  logic [MULT_BITS-1:0]  out_mult_q;
  logic                  out_last_q;
  status_e               out_status_q;

  div_req_t              div_req;
  div_res_t              div_res;
  logic                  in_accept;
  logic                  slot_free;
  logic                  out_load;
  logic                  quot_below;
  logic                  rem_zero;
  logic                  n_is_one;

  tdf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_comb begin
    in_accept  = in_valid_i && !in_stall_o;
    slot_free  = !out_valid_q || !out_stall_i;
    quot_below = div_res.quot < VALUE_BITS'(d_q);
    rem_zero   = div_res.rem == '0;
    n_is_one   = n_q == VALUE_BITS'(1);
  end

  always_comb begin
    in_stall_o       = state_q != ST_IDLE;
    out_load         = (state_q == ST_EMIT) && slot_free;
    div_req.start    = state_q == ST_START;
    div_req.dividend = n_q;
    div_req.divisor  = d_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (value_i < VALUE_BITS'(2)) ? ST_EMIT : ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (n_q[0]) begin
          state_d = (e_q != '0) ? ST_EMIT : ST_START;
        end
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_res.done) begin
          if (!inner_q && quot_below) begin
            state_d = ST_EMIT;
          end else if (inner_q && !rem_zero) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_START;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = pend_last_q ? ST_IDLE : ST_START;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    n_d           = n_q;
    d_d           = d_q;
    e_d           = e_q;
    inner_d       = inner_q;
    pend_prime_d  = pend_prime_q;
    pend_mult_d   = pend_mult_q;
    pend_last_d   = pend_last_q;
    pend_status_d = pend_status_q;
    unique case (state_q)
      ST_IDLE: begin
        n_d           = value_i;
        e_d           = '0;
        inner_d       = 1'b0;
        pend_prime_d  = '0;
        pend_mult_d   = '0;
        pend_last_d   = 1'b1;
        pend_status_d = (value_i == '0) ? STATUS_ZERO : STATUS_ONE;
      end
      ST_STRIP: begin
        if (!n_q[0]) begin
          n_d = n_q >> 1;
          e_d = e_q + MULT_BITS'(1);
        end else begin
          d_d           = DIV_BITS'(FIRST_ODD_DIVISOR);
          inner_d       = 1'b0;
          pend_prime_d  = VALUE_BITS'(EVEN_PRIME);
          pend_mult_d   = e_q;
          pend_last_d   = n_is_one;
          pend_status_d = STATUS_FACTOR;
        end
      end
      ST_WAIT: begin
        if (div_res.done) begin
          if (!inner_q) begin
            if (quot_below) begin
              pend_prime_d  = n_q;
              pend_mult_d   = MULT_BITS'(1);
              pend_last_d   = 1'b1;
              pend_status_d = STATUS_FACTOR;
            end else if (rem_zero) begin
              n_d     = div_res.quot;
              e_d     = MULT_BITS'(1);
              inner_d = 1'b1;
            end else begin
              d_d = d_q + DIV_BITS'(DIVISOR_STEP);
            end
          end else if (rem_zero) begin
            n_d = div_res.quot;
            e_d = e_q + MULT_BITS'(1);
          end else begin
            pend_prime_d  = VALUE_BITS'(d_q);
            pend_mult_d   = e_q;
            pend_last_d   = n_is_one;
            pend_status_d = STATUS_FACTOR;
            d_d           = d_q + DIV_BITS'(DIVISOR_STEP);
            inner_d       = 1'b0;
          end
        end
      end
      ST_START, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inner_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inner_q     <= inner_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q           <= n_d;
    d_q           <= d_d;
    e_q           <= e_d;
    pend_prime_q  <= pend_prime_d;
    pend_mult_q   <= pend_mult_d;
    pend_last_q   <= pend_last_d;
    pend_status_q <= pend_status_d;
    if (out_load) begin
      out_prime_q  <= pend_prime_q;
      out_mult_q   <= pend_mult_q;
      out_last_q   <= pend_last_q;
      out_status_q <= pend_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign prime_o        = out_prime_q;
  assign multiplicity_o = out_mult_q;
  assign last_o         = out_last_q;
  assign status_o       = out_status_q;

  a_odd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> d_q[0] && (d_q >= DIV_BITS'(FIRST_ODD_DIVISOR)))
    else $error("Trial divisor is not an odd value of at least three.");

  a_odd_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> n_q[0])
    else $error("Remainder still even during trial division.");

  a_factor_has_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (pend_status_q == STATUS_FACTOR) |-> (pend_mult_q != '0) && (pend_prime_q > 1))
    else $error("Factor beat without a prime or an exponent.");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("Accepted value did not start a factorization.");

endmodule

`default_nettype wire

@@ hw/rtl/tdf_divider.sv @@
`default_nettype none

module tdf_divider (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tdf_pkg::div_req_t req_i,
  output tdf_pkg::div_res_t    res_o
);
  import tdf_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_BITS-1:0]  cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [DIV_BITS-1:0]   rem_q, rem_d;
  logic [DIV_BITS-1:0]   div_q, div_d;

  logic [DIV_BITS:0]     shifted;
  logic [DIV_BITS+1:0]   diff;
  logic                  fits;

  always_comb begin
    shifted = {rem_q, quo_q[VALUE_BITS-1]};
    diff    = {1'b0, shifted} - {2'b00, div_q};
    fits    = ~diff[DIV_BITS+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      rem_d = fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
      cnt_d = cnt_q + STEP_BITS'(1);
      if (cnt_q == STEP_BITS'(VALUE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("Division started while the divider is busy.");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("Division finished without running.");

endmodule

`default_nettype wire
